// ===== hdl/rsi_pkg.sv =====
// rsi_pkg: shared constants and types for the ray/sphere intersection pipeline
// used by rsi_mul, rsi_sqrt and ray_sphere_intersect_top; no dependencies
package rsi_pkg;

  // chunk width of the partial-product multiplier
  localparam int unsigned MUL_CHUNK_W = 32;
  // register stages in rsi_mul
  localparam int unsigned MUL_LAT = 5;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd3;

  // status leaving the square root pipeline
  typedef struct packed {
    logic valid;
    logic exact;
  } rsi_root_stat_t;

endpackage

// ===== hdl/rsi_mul.sv =====
// rsi_mul: pipelined signed multiplier built from 32x32 partial products
// depends on rsi_pkg (MUL_CHUNK_W, MUL_LAT)
module rsi_mul
  import rsi_pkg::*;
#(
  parameter int unsigned A_W  = 67,
  parameter int unsigned B_W  = 67,
  parameter int unsigned SB_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [A_W-1:0]   a_i,
  input  logic signed [B_W-1:0]   b_i,
  input  logic [SB_W-1:0]         sb_i,
  output logic                    valid_o,
  output logic signed [A_W+B_W-1:0] p_o,
  output logic [SB_W-1:0]         sb_o
);

  localparam int unsigned NA    = (A_W + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
  localparam int unsigned NB    = (B_W + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
  localparam int unsigned MA_W  = NA * MUL_CHUNK_W;
  localparam int unsigned MB_W  = NB * MUL_CHUNK_W;
  localparam int unsigned PAD_W = MA_W + MB_W;
  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned PP_W  = 2 * MUL_CHUNK_W;

  logic [MUL_LAT-1:0] v_q;
  logic [SB_W-1:0]    sb_q [MUL_LAT];
  logic               neg_q [MUL_LAT-1];

  logic [A_W-1:0]   a_abs;
  logic [B_W-1:0]   b_abs;
  logic [MA_W-1:0]  ma_q;
  logic [MB_W-1:0]  mb_q;
  logic [PP_W-1:0]  pp_q [NA][NB];
  logic [PAD_W-1:0] row_d [NA];
  logic [PAD_W-1:0] row_q [NA];
  logic [PAD_W-1:0] tot_d;
  logic [PAD_W-1:0] tot_q;
  logic [P_W-1:0]   p_q;

  always_comb begin
    a_abs = a_i[A_W-1] ? -a_i : a_i;
    b_abs = b_i[B_W-1] ? -b_i : b_i;
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (PAD_W'(pp_q[i][j]) << (j * MUL_CHUNK_W));
      end
    end
  end

  always_comb begin
    tot_d = '0;
    for (int i = 0; i < NA; i++) begin
      tot_d = tot_d + (row_q[i] << (i * MUL_CHUNK_W));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[MUL_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0]  <= sb_i;
    neg_q[0] <= a_i[A_W-1] ^ b_i[B_W-1];
    for (int k = 1; k < MUL_LAT; k++) begin
      sb_q[k] <= sb_q[k-1];
    end
    for (int k = 1; k < MUL_LAT - 1; k++) begin
      neg_q[k] <= neg_q[k-1];
    end
    // magnitudes
    ma_q <= MA_W'(a_abs);
    mb_q <= MB_W'(b_abs);
    // partial products
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= PP_W'(ma_q[i*MUL_CHUNK_W +: MUL_CHUNK_W])
                    * PP_W'(mb_q[j*MUL_CHUNK_W +: MUL_CHUNK_W]);
      end
    end
    // row sums, total, sign
    for (int i = 0; i < NA; i++) begin
      row_q[i] <= row_d[i];
    end
    tot_q <= tot_d;
    p_q   <= neg_q[MUL_LAT-2] ? -tot_q[P_W-1:0] : tot_q[P_W-1:0];
  end

  assign valid_o = v_q[MUL_LAT-1];
  assign p_o     = $signed(p_q);
  assign sb_o    = sb_q[MUL_LAT-1];

endmodule

// ===== hdl/rsi_sqrt.sv =====
// rsi_sqrt: fully pipelined floor square root, one result bit per stage
// depends on rsi_pkg (rsi_root_stat_t)
module rsi_sqrt
  import rsi_pkg::*;
#(
  parameter int unsigned IN_W = 168,
  parameter int unsigned SB_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [IN_W-1:0]       rad_i,
  input  logic [SB_W-1:0]       sb_i,
  output rsi_root_stat_t        stat_o,
  output logic [IN_W/2-1:0]     root_o,
  output logic [SB_W-1:0]       sb_o
);

  localparam int unsigned RT_W = IN_W / 2;
  localparam int unsigned RM_W = RT_W + 2;
  localparam int unsigned TR_W = RT_W + 4;

  logic            v_q    [RT_W];
  logic [RM_W-1:0] rem_q  [RT_W];
  logic [RT_W-1:0] root_q [RT_W];
  logic [IN_W-1:0] x_q    [RT_W];
  logic [SB_W-1:0] sb_q   [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    logic            v_in;
    logic [RM_W-1:0] rem_in;
    logic [RT_W-1:0] root_in;
    logic [IN_W-1:0] x_in;
    logic [SB_W-1:0] sb_in;
    logic [TR_W-1:0] cur;
    logic [TR_W-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = rad_i;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_in, x_in[IN_W-1 -: 2]};
    assign trial = TR_W'({root_in, 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? RM_W'(cur - trial) : cur[RM_W-1:0];
      root_q[k] <= {root_in[RT_W-2:0], ge};
      x_q[k]    <= x_in << 2;
      sb_q[k]   <= sb_in;
    end
  end

  assign stat_o.valid = v_q[RT_W-1];
  assign stat_o.exact = (rem_q[RT_W-1] == '0);
  assign root_o       = root_q[RT_W-1];
  assign sb_o         = sb_q[RT_W-1];

endmodule

// ===== hdl/ray_sphere_intersect_top.sv =====
// ray_sphere_intersect_top: streaming ray/sphere hit test in signed fixed point
// depends on rsi_pkg, rsi_mul and rsi_sqrt
//
// One ray per start_i pulse, one ray per clock if wanted: busy_o is always low
// and the result comes out as a single-cycle valid_o strobe with hit_o and
// hit_distance_o. The receiver cannot stall, so there is no backpressure
// anywhere. The pipeline holds the bit-serial square root (one root bit per
// stage, S_W = 2*COORD_WIDTH + 4 + FRAC_BITS) and the restoring divider (one
// quotient bit per stage, QB = COORD_WIDTH + 1).
// All quadratic terms are exact: a = d.d, h = d.l, c = l.l - r^2 with
// l = origin - center, discriminant h^2 - a*c. Both roots are floored onto the
// fixed-point grid, the smaller one strictly inside (near, far) wins, and a
// miss returns far_limit. The user must write sphere center and radius through
// the cfg port only while no ray is in flight; the block does not enforce it.
module ray_sphere_intersect_top
  import rsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata_i,
  // ray transaction
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] near_limit_i,
  input  logic signed [COORD_WIDTH-1:0] far_limit_i,
  // result transaction
  output logic                          valid_o,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] hit_distance_o
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned L_W    = W + 1;        // origin - center
  localparam int unsigned DD_W   = 2 * W;
  localparam int unsigned DL_W   = 2 * W + 1;
  localparam int unsigned LL_W   = 2 * W + 2;
  localparam int unsigned RR_W   = 2 * W - 2;
  localparam int unsigned A_W    = 2 * W + 2;
  localparam int unsigned H_W    = 2 * W + 3;
  localparam int unsigned C_W    = 2 * W + 5;
  localparam int unsigned HH_W   = 2 * H_W;
  localparam int unsigned AC_W   = A_W + C_W;
  localparam int unsigned D_W    = 4 * W + 8;    // discriminant
  localparam int unsigned SQ_W   = D_W + 2 * FRAC_BITS;
  localparam int unsigned S_W    = SQ_W / 2;     // square root
  localparam int unsigned N_W    = S_W + 2;      // root numerators
  localparam int unsigned QB     = W + 1;        // quotient bits
  localparam int unsigned T_W    = W + 3;        // signed root
  localparam int unsigned CMP_W  = N_W + A_W + QB;
  localparam int unsigned ACSB_W = H_W + 2 * W;
  localparam int unsigned SQSB_W = 1 + 2 * W + N_W + A_W;
  localparam int unsigned LATENCY = 3 + MUL_LAT + 1 + S_W + 3 + QB + 2;

  // one divider lane and the data riding alongside both lanes
  typedef struct packed {
    logic [A_W-1:0] r;
    logic [QB-1:0]  x;
    logic           neg;
    logic           ok;
  } lane_t;

  typedef struct packed {
    logic [A_W-1:0]        a;
    logic signed [W-1:0]   near;
    logic signed [W-1:0]   far;
  } side_t;

  function automatic lane_t div_step(lane_t in, logic [A_W-1:0] a);
    logic [A_W:0] cur;
    logic         ge;
    lane_t        out;
    cur     = {in.r, in.x[QB-1]};
    ge      = cur >= {1'b0, a};
    out     = in;
    out.r   = ge ? A_W'(cur - {1'b0, a}) : cur[A_W-1:0];
    out.x   = {in.x[QB-2:0], ge};
    return out;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] ctr_q [3];
  logic [W-2:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
      rad_q    <= (W-1)'(1) << FRAC_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X: ctr_q[0] <= cfg_wdata_i;
        REG_CENTER_Y: ctr_q[1] <= cfg_wdata_i;
        REG_CENTER_Z: ctr_q[2] <= cfg_wdata_i;
        REG_RADIUS:   rad_q    <= cfg_wdata_i[W-2:0];
        default:      rad_q    <= rad_q;
      endcase
    end
  end

  // fully pipelined, never refuses a transaction
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // s1: capture ray, relative origin
  // ---------------------------------------------------------------------------
  logic                  s1_v_q;
  logic signed [W-1:0]   s1_d_q [3];
  logic signed [L_W-1:0] s1_l_q [3];
  logic signed [W-1:0]   s1_near_q, s1_far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    s1_d_q[0] <= dir_x_i;
    s1_d_q[1] <= dir_y_i;
    s1_d_q[2] <= dir_z_i;
    s1_l_q[0] <= L_W'(origin_x_i) - L_W'(ctr_q[0]);
    s1_l_q[1] <= L_W'(origin_y_i) - L_W'(ctr_q[1]);
    s1_l_q[2] <= L_W'(origin_z_i) - L_W'(ctr_q[2]);
    s1_near_q <= near_limit_i;
    s1_far_q  <= far_limit_i;
  end

  // ---------------------------------------------------------------------------
  // s2: per-axis products
  // ---------------------------------------------------------------------------
  logic                   s2_v_q;
  logic signed [DD_W-1:0] s2_dd_q [3];
  logic signed [DL_W-1:0] s2_dl_q [3];
  logic signed [LL_W-1:0] s2_ll_q [3];
  logic [RR_W-1:0]        s2_rr_q;
  logic signed [W-1:0]    s2_near_q, s2_far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else         s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s2_dd_q[i] <= DD_W'(s1_d_q[i]) * DD_W'(s1_d_q[i]);
      s2_dl_q[i] <= DL_W'(s1_d_q[i]) * DL_W'(s1_l_q[i]);
      s2_ll_q[i] <= LL_W'(s1_l_q[i]) * LL_W'(s1_l_q[i]);
    end
    s2_rr_q   <= RR_W'(rad_q) * RR_W'(rad_q);
    s2_near_q <= s1_near_q;
    s2_far_q  <= s1_far_q;
  end

  // ---------------------------------------------------------------------------
  // s3: quadratic coefficients a, h (half b), c
  // ---------------------------------------------------------------------------
  logic                  s3_v_q;
  logic signed [A_W-1:0] s3_a_q;
  logic signed [H_W-1:0] s3_h_q;
  logic signed [C_W-1:0] s3_c_q;
  logic signed [W-1:0]   s3_near_q, s3_far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else         s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    s3_a_q <= A_W'(s2_dd_q[0]) + A_W'(s2_dd_q[1]) + A_W'(s2_dd_q[2]);
    s3_h_q <= H_W'(s2_dl_q[0]) + H_W'(s2_dl_q[1]) + H_W'(s2_dl_q[2]);
    s3_c_q <= C_W'(s2_ll_q[0]) + C_W'(s2_ll_q[1]) + C_W'(s2_ll_q[2])
            - $signed(C_W'(s2_rr_q));
    s3_near_q <= s2_near_q;
    s3_far_q  <= s2_far_q;
  end

  // ---------------------------------------------------------------------------
  // h*h and a*c in parallel
  // ---------------------------------------------------------------------------
  logic                   hh_v, ac_v;
  logic signed [HH_W-1:0] hh_p;
  logic signed [AC_W-1:0] ac_p;
  logic [A_W-1:0]         hh_sb;
  logic [ACSB_W-1:0]      ac_sb;

  rsi_mul #(
    .A_W (H_W),
    .B_W (H_W),
    .SB_W(A_W)
  ) u_mul_hh (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s3_v_q),
    .a_i    (s3_h_q),
    .b_i    (s3_h_q),
    .sb_i   (s3_a_q),
    .valid_o(hh_v),
    .p_o    (hh_p),
    .sb_o   (hh_sb)
  );

  rsi_mul #(
    .A_W (A_W),
    .B_W (C_W),
    .SB_W(ACSB_W)
  ) u_mul_ac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s3_v_q),
    .a_i    (s3_a_q),
    .b_i    (s3_c_q),
    .sb_i   ({s3_h_q, s3_near_q, s3_far_q}),
    .valid_o(ac_v),
    .p_o    (ac_p),
    .sb_o   (ac_sb)
  );

  // ---------------------------------------------------------------------------
  // s4: discriminant, scaled -h
  // ---------------------------------------------------------------------------
  logic signed [D_W-1:0] disc_d;
  logic signed [H_W-1:0] mul_h;

  logic                  s4_v_q;
  logic signed [D_W-1:0] s4_disc_q;
  logic [A_W-1:0]        s4_a_q;
  logic signed [N_W-1:0] s4_p_q;
  logic signed [W-1:0]   s4_near_q, s4_far_q;
  logic                  s4_ok_q;

  assign disc_d = D_W'(hh_p) - D_W'(ac_p);
  assign mul_h  = $signed(ac_sb[2*W +: H_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else         s4_v_q <= hh_v && ac_v;
  end

  always_ff @(posedge clk_i) begin
    s4_disc_q <= disc_d;
    s4_a_q    <= hh_sb;
    s4_p_q    <= (-N_W'(mul_h)) <<< FRAC_BITS;
    s4_near_q <= $signed(ac_sb[W +: W]);
    s4_far_q  <= $signed(ac_sb[W-1:0]);
    // zero direction or negative discriminant is a miss
    s4_ok_q   <= (hh_sb != '0) && !disc_d[D_W-1];
  end

  // ---------------------------------------------------------------------------
  // square root of disc << 2*FRAC_BITS
  // ---------------------------------------------------------------------------
  rsi_root_stat_t  sq_stat;
  logic [S_W-1:0]  sq_root;
  logic [SQSB_W-1:0] sq_sb;

  rsi_sqrt #(
    .IN_W(SQ_W),
    .SB_W(SQSB_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s4_v_q),
    .rad_i  ({s4_disc_q, (2*FRAC_BITS)'(0)}),
    .sb_i   ({s4_ok_q, s4_far_q, s4_near_q, s4_p_q, s4_a_q}),
    .stat_o (sq_stat),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  logic signed [N_W-1:0] sq_p;
  assign sq_p = $signed(sq_sb[A_W +: N_W]);

  // ---------------------------------------------------------------------------
  // s5: root numerators; the lower one steps down when the root is inexact
  // ---------------------------------------------------------------------------
  logic                  s5_v_q;
  logic signed [N_W-1:0] s5_n1_q, s5_n2_q;
  side_t                 s5_side_q;
  logic                  s5_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else         s5_v_q <= sq_stat.valid;
  end

  always_ff @(posedge clk_i) begin
    s5_n1_q        <= sq_p + $signed(N_W'(sq_root));
    // p - s - 1 + exact = p + ~s + exact
    s5_n2_q        <= sq_p + $signed(~N_W'(sq_root)) + $signed(N_W'(sq_stat.exact));
    s5_side_q.a    <= sq_sb[A_W-1:0];
    s5_side_q.near <= $signed(sq_sb[A_W+N_W +: W]);
    s5_side_q.far  <= $signed(sq_sb[A_W+N_W+W +: W]);
    s5_ok_q        <= sq_sb[SQSB_W-1];
  end

  // ---------------------------------------------------------------------------
  // s6: magnitudes for the divider
  // ---------------------------------------------------------------------------
  logic           s6_v_q;
  logic [N_W-1:0] s6_m1_q, s6_m2_q;
  logic           s6_neg1_q, s6_neg2_q;
  side_t          s6_side_q;
  logic           s6_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_v_q <= 1'b0;
    else         s6_v_q <= s5_v_q;
  end

  always_ff @(posedge clk_i) begin
    s6_m1_q   <= s5_n1_q[N_W-1] ? -s5_n1_q : s5_n1_q;
    s6_m2_q   <= s5_n2_q[N_W-1] ? -s5_n2_q : s5_n2_q;
    s6_neg1_q <= s5_n1_q[N_W-1];
    s6_neg2_q <= s5_n2_q[N_W-1];
    s6_side_q <= s5_side_q;
    s6_ok_q   <= s5_ok_q;
  end

  // ---------------------------------------------------------------------------
  // s7: range check and divider seed; a quotient of 2^QB or more is a miss
  // ---------------------------------------------------------------------------
  logic [N_W+A_W-1:0] hi1, hi2;
  logic               big1, big2;
  logic               s7_v_q;
  lane_t              s7_l1_q, s7_l2_q;
  side_t              s7_side_q;

  assign hi1  = (N_W+A_W)'(s6_m1_q) >> QB;
  assign hi2  = (N_W+A_W)'(s6_m2_q) >> QB;
  assign big1 = CMP_W'(s6_m1_q) >= (CMP_W'(s6_side_q.a) << QB);
  assign big2 = CMP_W'(s6_m2_q) >= (CMP_W'(s6_side_q.a) << QB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_v_q <= 1'b0;
    else         s7_v_q <= s6_v_q;
  end

  always_ff @(posedge clk_i) begin
    s7_l1_q.r   <= hi1[A_W-1:0];
    s7_l1_q.x   <= s6_m1_q[QB-1:0];
    s7_l1_q.neg <= s6_neg1_q;
    s7_l1_q.ok  <= s6_ok_q && !big1;
    s7_l2_q.r   <= hi2[A_W-1:0];
    s7_l2_q.x   <= s6_m2_q[QB-1:0];
    s7_l2_q.neg <= s6_neg2_q;
    s7_l2_q.ok  <= s6_ok_q && !big2;
    s7_side_q   <= s6_side_q;
  end

  // ---------------------------------------------------------------------------
  // restoring divider, one quotient bit per stage, two lanes
  // ---------------------------------------------------------------------------
  logic  dv_v_q    [QB];
  lane_t dv_l1_q   [QB];
  lane_t dv_l2_q   [QB];
  side_t dv_side_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic  v_in;
    lane_t l1_in, l2_in;
    side_t side_in;

    if (k == 0) begin : g_first
      assign v_in    = s7_v_q;
      assign l1_in   = s7_l1_q;
      assign l2_in   = s7_l2_q;
      assign side_in = s7_side_q;
    end else begin : g_next
      assign v_in    = dv_v_q[k-1];
      assign l1_in   = dv_l1_q[k-1];
      assign l2_in   = dv_l2_q[k-1];
      assign side_in = dv_side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k] <= 1'b0;
      else         dv_v_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      dv_l1_q[k]   <= div_step(l1_in, side_in.a);
      dv_l2_q[k]   <= div_step(l2_in, side_in.a);
      dv_side_q[k] <= side_in;
    end
  end

  // ---------------------------------------------------------------------------
  // s8: floor toward minus infinity for negative numerators
  // ---------------------------------------------------------------------------
  lane_t                 q1, q2;
  side_t                 dv_side;
  logic                  s8_v_q;
  logic signed [T_W-1:0] s8_t1_q, s8_t2_q;
  logic                  s8_ok1_q, s8_ok2_q;
  logic signed [W-1:0]   s8_near_q, s8_far_q;

  assign q1      = dv_l1_q[QB-1];
  assign q2      = dv_l2_q[QB-1];
  assign dv_side = dv_side_q[QB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s8_v_q <= 1'b0;
    else         s8_v_q <= dv_v_q[QB-1];
  end

  // -(q + rem_nonzero) = ~q + !rem_nonzero
  always_ff @(posedge clk_i) begin
    s8_t1_q   <= q1.neg ? $signed(~T_W'(q1.x) + T_W'(q1.r == '0)) : $signed(T_W'(q1.x));
    s8_t2_q   <= q2.neg ? $signed(~T_W'(q2.x) + T_W'(q2.r == '0)) : $signed(T_W'(q2.x));
    s8_ok1_q  <= q1.ok;
    s8_ok2_q  <= q2.ok;
    s8_near_q <= dv_side.near;
    s8_far_q  <= dv_side.far;
  end

  // ---------------------------------------------------------------------------
  // s9: interval test, nearer root first
  // ---------------------------------------------------------------------------
  logic in1, in2;
  logic valid_q, hit_q;
  logic signed [W-1:0] dist_q;

  assign in1 = s8_ok1_q && (s8_t1_q > T_W'(s8_near_q)) && (s8_t1_q < T_W'(s8_far_q));
  assign in2 = s8_ok2_q && (s8_t2_q > T_W'(s8_near_q)) && (s8_t2_q < T_W'(s8_far_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= s8_v_q;
  end

  always_ff @(posedge clk_i) begin
    hit_q <= in1 || in2;
    priority if (in2) begin
      dist_q <= s8_t2_q[W-1:0];
    end else if (in1) begin
      dist_q <= s8_t1_q[W-1:0];
    end else begin
      dist_q <= s8_far_q;
    end
  end

  assign valid_o        = valid_q;
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LATENCY))
    else $error("result strobe without a transaction LATENCY cycles earlier");

  a_miss_returns_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !hit_o) |-> (hit_distance_o == $past(far_limit_i, LATENCY)))
    else $error("miss does not return the far limit of its transaction");

  a_hit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> ((hit_distance_o > $past(near_limit_i, LATENCY))
                         && (hit_distance_o < $past(far_limit_i, LATENCY))))
    else $error("hit distance outside the open interval of its transaction");

endmodule
